@@ rtl/swpt_pkg.sv @@
// shared types, sizes and the rank function of the sliding window percentile tracker
// no dependencies; imported by swpt_ring, swpt_sorted, the top level and the testbench
package swpt_pkg;

   localparam int WINDOW_MAX  = 64;
   localparam int IDX_BITS    = $clog2(WINDOW_MAX);
   localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);
   localparam int IN_BITS     = 32;
   localparam int SAMPLE_BITS = 31;

   // floor(95*m/100) as (m*RANK_RECIP) >> RANK_SHIFT, exact for m below 4096
   localparam int RANK_SHIFT  = 16;
   localparam int RANK_RECIP  = (95 * (1 << RANK_SHIFT) + 99) / 100;
   localparam int PROD_BITS   = CNT_BITS + RANK_SHIFT;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   typedef enum logic [1:0] {
      SORT_OP_DELETE,
      SORT_OP_INSERT,
      SORT_OP_READ
   } sort_op_type;

   typedef struct packed {
      logic                 start;
      sort_op_type          op;
      sample_type           key;
      logic [CNT_BITS-1:0]  count;
      logic [IDX_BITS-1:0]  addr;
   } sort_cmd_type;

   typedef struct packed {
      logic       done;
      sample_type data;
   } sort_status_type;

   typedef enum logic [1:0] {
      SS_IDLE,
      SS_DELETE,
      SS_INSERT,
      SS_READ
   } sort_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVICT,
      ST_DELETE,
      ST_PUSH,
      ST_INSERT,
      ST_SELECT,
      ST_FINISH
   } main_state_type;

   // rank floor(95*(n-1)/100) of a window holding n >= 1 samples
   function automatic logic [IDX_BITS-1:0] rank_of(input logic [CNT_BITS-1:0] n);
      logic [CNT_BITS-1:0]  m;
      logic [PROD_BITS-1:0] prod;
      m    = n - CNT_BITS'(1);
      prod = PROD_BITS'(m) * PROD_BITS'(RANK_RECIP);
      return prod[RANK_SHIFT +: IDX_BITS];
   endfunction

endpackage

@@ rtl/swpt_ring.sv @@
// ring memory of recent samples, one write and one registered read per cycle
// depends on swpt_pkg
module swpt_ring (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [swpt_pkg::IDX_BITS-1:0] wr_addr,
   input  swpt_pkg::sample_type          wr_data,
   input  logic                          rd_en,
   input  logic [swpt_pkg::IDX_BITS-1:0] rd_addr,
   output swpt_pkg::sample_type          rd_data
);
   import swpt_pkg::*;

   sample_type ring_mem [WINDOW_MAX];
   sample_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/swpt_sorted.sv @@
// sorted copy of the window with one shared comparator: delete, insert and rank read
// depends on swpt_pkg
module swpt_sorted (
   input  logic                      clock,
   input  logic                      reset,
   input  swpt_pkg::sort_cmd_type    cmd,
   output swpt_pkg::sort_status_type status
);
   import swpt_pkg::*;

   sample_type           sort_mem [WINDOW_MAX];
   sample_type           rd_data_ff;

   sort_state_type       state_ff, state_in;
   sample_type           key_ff, key_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [CNT_BITS-1:0]  iss_ff, iss_in;
   logic                 pend_v_ff, pend_v_in;
   logic [IDX_BITS-1:0]  pend_idx_ff, pend_idx_in;
   logic                 found_ff, found_in;

   logic                 rd_en;
   logic [IDX_BITS-1:0]  rd_addr;
   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_addr;
   sample_type           wr_data;
   logic                 done;
   logic                 greater;
   logic                 equal;
   logic [CNT_BITS-1:0]  iss_dec;

   // the shared comparator
   assign greater = rd_data_ff > key_ff;
   assign equal   = rd_data_ff == key_ff;
   assign iss_dec = iss_ff - CNT_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= SS_IDLE;
         pend_v_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pend_v_ff <= pend_v_in;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      count_ff    <= count_in;
      iss_ff      <= iss_in;
      pend_idx_ff <= pend_idx_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sort_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= sort_mem[rd_addr];
      end
   end

   always_comb begin
      state_in    = state_ff;
      key_in      = key_ff;
      count_in    = count_ff;
      iss_in      = iss_ff;
      pend_v_in   = 1'b0;
      pend_idx_in = pend_idx_ff;
      found_in    = found_ff;
      rd_en       = 1'b0;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = key_ff;
      done        = 1'b0;
      case (state_ff)
         SS_IDLE: begin
            if (cmd.start) begin
               key_in   = cmd.key;
               count_in = cmd.count;
               found_in = 1'b0;
               case (cmd.op)
                  SORT_OP_DELETE: begin
                     iss_in   = '0;
                     state_in = SS_DELETE;
                  end
                  SORT_OP_INSERT: begin
                     iss_in   = cmd.count;
                     state_in = SS_INSERT;
                  end
                  SORT_OP_READ: begin
                     rd_en    = 1'b1;
                     rd_addr  = cmd.addr;
                     state_in = SS_READ;
                  end
                  default: begin
                     state_in = SS_IDLE;
                  end
               endcase
            end
         end
         // walk upward, drop the first match, shift the rest down by one
         SS_DELETE: begin
            if (iss_ff < count_ff) begin
               rd_en       = 1'b1;
               rd_addr     = iss_ff[IDX_BITS-1:0];
               iss_in      = iss_ff + CNT_BITS'(1);
               pend_v_in   = 1'b1;
               pend_idx_in = iss_ff[IDX_BITS-1:0];
            end
            if (pend_v_ff) begin
               if (found_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = pend_idx_ff - IDX_BITS'(1);
                  wr_data = rd_data_ff;
               end else if (equal) begin
                  found_in = 1'b1;
               end
            end
            if (iss_ff == count_ff && !pend_v_ff) begin
               done     = 1'b1;
               state_in = SS_IDLE;
            end
         end
         // walk downward, move larger entries up, drop the key in the gap
         SS_INSERT: begin
            if (iss_ff != '0) begin
               rd_en       = 1'b1;
               rd_addr     = iss_dec[IDX_BITS-1:0];
               iss_in      = iss_dec;
               pend_v_in   = 1'b1;
               pend_idx_in = iss_dec[IDX_BITS-1:0];
            end
            if (pend_v_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff + IDX_BITS'(1);
               if (greater) begin
                  wr_data = rd_data_ff;
               end else begin
                  wr_data   = key_ff;
                  pend_v_in = 1'b0;
                  done      = 1'b1;
                  state_in  = SS_IDLE;
               end
            end else if (iss_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = key_ff;
               done     = 1'b1;
               state_in = SS_IDLE;
            end
         end
         SS_READ: begin
            done     = 1'b1;
            state_in = SS_IDLE;
         end
         default: begin
            state_in = SS_IDLE;
         end
      endcase
   end

   assign status.done = done;
   assign status.data = rd_data_ff;

endmodule

@@ rtl/sliding_window_p95_tracker_top.sv @@
// top level of the sliding window 95th percentile tracker: handshakes, ring control, result
// depends on swpt_pkg, swpt_ring and swpt_sorted
//
//   channel   direction  handshake           payload
//   req       in         req_valid/req_stall  req_latency_sample[31:0] signed
//   rsp       out        rsp_valid/rsp_stall  rsp_p95_latency[30:0], rsp_window_fill[6:0]
//   csr       in         csr_valid/csr_ready  csr_window_size[6:0]
//
// the time from one req acceptance to the next is set by the walks over the sorted memory,
// whose length grows with the samples held: an insert walk while the window is filling and
// a delete walk then an insert walk once it is full; the sorted memory has one read and one
// write port and one comparator; with window size zero a transaction skips the walks
// reset is synchronous and gives size 64 and an empty window; no clearing pass
// req_stall is high while a transaction is at work and while a csr write is offered; a
// result stalled on rsp holds the output register, the next transaction still enters and
// waits only at its own finish step, for as long as the earlier result stays stalled
module sliding_window_p95_tracker_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [swpt_pkg::IN_BITS-1:0]  req_latency_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output swpt_pkg::sample_type          rsp_p95_latency,
   output logic [swpt_pkg::CNT_BITS-1:0] rsp_window_fill,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [swpt_pkg::CNT_BITS-1:0] csr_window_size
);
   import swpt_pkg::*;

   main_state_type        state_ff, state_in;
   logic [CNT_BITS-1:0]   size_ff, size_in;
   logic [CNT_BITS-1:0]   fill_ff, fill_in;
   logic [IDX_BITS-1:0]   oldest_ff, oldest_in;
   sample_type            sample_ff, sample_in;
   sample_type            result_ff, result_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sample_type            rsp_p95_ff, rsp_p95_in;
   logic [CNT_BITS-1:0]   rsp_fill_ff, rsp_fill_in;

   sort_cmd_type          sort_cmd;
   sort_status_type       sort_status;

   logic                  ring_wr_en;
   logic [IDX_BITS-1:0]   ring_wr_addr;
   logic                  ring_rd_en;
   sample_type            ring_rd_data;

   logic                  full;
   logic [CNT_BITS:0]     slot_sum;
   logic [CNT_BITS:0]     slot_wrap;
   logic [IDX_BITS-1:0]   slot;
   logic [CNT_BITS-1:0]   oldest_inc;
   logic [IDX_BITS-1:0]   oldest_next;
   sample_type            clamped;
   logic [CNT_BITS-1:0]   csr_size;

   // negative samples clamp to zero
   assign clamped = req_latency_sample[IN_BITS-1] ? '0 : req_latency_sample[SAMPLE_BITS-1:0];

   // writes above the window depth saturate
   assign csr_size = (csr_window_size > CNT_BITS'(WINDOW_MAX)) ?
                     CNT_BITS'(WINDOW_MAX) : csr_window_size;

   assign full = (fill_ff == size_ff);

   // next ring slot: oldest + fill, wrapped once (sum stays below twice the size)
   assign slot_sum  = (CNT_BITS + 1)'(oldest_ff) + (CNT_BITS + 1)'(fill_ff);
   assign slot_wrap = (slot_sum >= (CNT_BITS + 1)'(size_ff)) ?
                      slot_sum - (CNT_BITS + 1)'(size_ff) : slot_sum;
   assign slot      = full ? oldest_ff : slot_wrap[IDX_BITS-1:0];

   assign oldest_inc  = CNT_BITS'(oldest_ff) + CNT_BITS'(1);
   assign oldest_next = (oldest_inc >= size_ff) ? '0 : oldest_inc[IDX_BITS-1:0];

   assign ring_wr_addr = slot;

   swpt_ring u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (sample_ff),
      .rd_en   (ring_rd_en),
      .rd_addr (oldest_ff),
      .rd_data (ring_rd_data)
   );

   swpt_sorted u_sorted (
      .clock  (clock),
      .reset  (reset),
      .cmd    (sort_cmd),
      .status (sort_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= CNT_BITS'(WINDOW_MAX);
         fill_ff      <= '0;
         oldest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      result_ff   <= result_in;
      rsp_p95_ff  <= rsp_p95_in;
      rsp_fill_ff <= rsp_fill_in;
   end

   always_comb begin
      state_in       = state_ff;
      size_in        = size_ff;
      fill_in        = fill_ff;
      oldest_in      = oldest_ff;
      sample_in      = sample_ff;
      result_in      = result_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_p95_in     = rsp_p95_ff;
      rsp_fill_in    = rsp_fill_ff;
      req_stall      = 1'b1;
      csr_ready      = 1'b0;
      ring_wr_en     = 1'b0;
      ring_rd_en     = 1'b0;
      sort_cmd.start = 1'b0;
      sort_cmd.op    = SORT_OP_READ;
      sort_cmd.key   = sample_ff;
      sort_cmd.count = fill_ff;
      sort_cmd.addr  = rank_of(fill_ff);
      case (state_ff)
         ST_IDLE: begin
            // a csr write goes first, so it never lands beside a req transaction
            req_stall = csr_valid;
            csr_ready = 1'b1;
            if (req_valid && !csr_valid) begin
               sample_in = clamped;
               if (size_ff == '0) begin
                  // tracking disabled: drop the sample, report an empty window
                  fill_in   = '0;
                  oldest_in = '0;
                  result_in = '0;
                  state_in  = ST_FINISH;
               end else if (full) begin
                  // fetch the sample about to be overwritten
                  ring_rd_en = 1'b1;
                  state_in   = ST_EVICT;
               end else begin
                  state_in = ST_PUSH;
               end
            end
            if (csr_valid && csr_size != size_ff) begin
               // a new size empties the window
               size_in   = csr_size;
               fill_in   = '0;
               oldest_in = '0;
            end
         end
         ST_EVICT: begin
            sort_cmd.start = 1'b1;
            sort_cmd.op    = SORT_OP_DELETE;
            sort_cmd.key   = ring_rd_data;
            sort_cmd.count = fill_ff;
            state_in       = ST_DELETE;
         end
         ST_DELETE: begin
            if (sort_status.done) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            ring_wr_en     = 1'b1;
            sort_cmd.start = 1'b1;
            sort_cmd.op    = SORT_OP_INSERT;
            sort_cmd.key   = sample_ff;
            if (full) begin
               sort_cmd.count = fill_ff - CNT_BITS'(1);
               oldest_in      = oldest_next;
            end else begin
               sort_cmd.count = fill_ff;
               fill_in        = fill_ff + CNT_BITS'(1);
            end
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            if (sort_status.done) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            // rank read, taken by the sorted unit once it is back in idle;
            // fill already holds the new count
            sort_cmd.start = 1'b1;
            sort_cmd.op    = SORT_OP_READ;
            sort_cmd.addr  = rank_of(fill_ff);
            if (sort_status.done) begin
               result_in = sort_status.data;
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_p95_in   = result_ff;
               rsp_fill_in  = fill_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_p95_latency = rsp_p95_ff;
   assign rsp_window_fill = rsp_fill_ff;

   // an accepted transaction always leaves idle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != ST_IDLE)
      else $error("accepted transaction did not start");

   // the window never holds more than its size
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= size_ff)
      else $error("fill count above window size");

   // oldest position stays inside the window, and a zero size holds nothing
   assert property (@(posedge clock) disable iff (reset)
      (size_ff == '0) ? (fill_ff == '0 && oldest_ff == '0)
                      : (CNT_BITS'(oldest_ff) < size_ff))
      else $error("ring pointers out of range");

   // a new result is loaded only from the finish step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result presented outside finish");

endmodule

@@ verif/sliding_window_p95_tracker_top_tb.sv @@
// self-checking testbench for sliding_window_p95_tracker_top: random and directed latency traffic
// a scoreboard class predicts the p95 and fill of each result from its own window copy
// depends on swpt_pkg and the rtl top level only
module sliding_window_p95_tracker_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import swpt_pkg::*;

   // one predicted result transaction
   typedef struct {
      sample_type          p95;
      logic [CNT_BITS-1:0] fill;
   } p95_result_type;

   // window predictor and result check
   class p95_scoreboard;
      int unsigned    mismatches;
      int unsigned    latencies_seen;
      int unsigned    results_seen;
      int unsigned    size_writes;
      int unsigned    window_size;
      int unsigned    ring_head;
      int unsigned    count_held;
      sample_type     lat_ring[WINDOW_MAX];
      p95_result_type expected_q[$];

      function new();
         window_size = WINDOW_MAX;
         ring_head   = 0;
         count_held  = 0;
      endfunction

      // size writes saturate at the window maximum; only a real change empties the window
      function void write_window_size(logic [CNT_BITS-1:0] value);
         int unsigned sz;
         sz = (value > WINDOW_MAX) ? WINDOW_MAX : value;
         size_writes++;
         if (sz != window_size) begin
            window_size = sz;
            ring_head   = 0;
            count_held  = 0;
         end
      endfunction

      // push one accepted latency and queue the result it must produce
      function void note_latency(logic [IN_BITS-1:0] raw);
         sample_type     clamped;
         sample_type     key;
         sample_type     ordered[WINDOW_MAX];
         p95_result_type res;
         int unsigned    i;
         int unsigned    j;
         clamped = raw[IN_BITS-1] ? '0 : raw[SAMPLE_BITS-1:0];
         latencies_seen++;
         if (window_size == 0) begin
            ring_head  = 0;
            count_held = 0;
            res.p95    = '0;
            res.fill   = '0;
         end else begin
            lat_ring[(ring_head + count_held) % window_size] = clamped;
            if (count_held < window_size) count_held++;
            else ring_head = (ring_head + 1) % window_size;
            for (i = 0; i < count_held; i++) begin
               key = lat_ring[(ring_head + i) % window_size];
               j = i;
               while (j > 0 && ordered[j-1] > key) begin
                  ordered[j] = ordered[j-1];
                  j--;
               end
               ordered[j] = key;
            end
            res.p95  = ordered[(95 * (count_held - 1)) / 100];
            res.fill = CNT_BITS'(count_held);
         end
         expected_q = {expected_q, res};
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_p95(sample_type p95, logic [CNT_BITS-1:0] fill);
         p95_result_type want;
         results_seen++;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result p95=%0d fill=%0d", p95, fill));
            return;
         end
         want = expected_q[0];
         expected_q.delete(0);
         if (p95 !== want.p95)
            report_mismatch($sformatf("p95 got %0d want %0d", p95, want.p95));
         if (fill !== want.fill)
            report_mismatch($sformatf("fill got %0d want %0d", fill, want.fill));
      endtask
   endclass

   // dut signals, all inputs known from time zero
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [IN_BITS-1:0]  req_latency_sample = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   sample_type          rsp_p95_latency;
   logic [CNT_BITS-1:0] rsp_window_fill;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CNT_BITS-1:0] csr_window_size = '0;

   // idling knobs per phase, in percent
   int unsigned idle_pct  = 0;
   int unsigned stall_pct = 0;
   // cycles left in a forced receiver hold-off
   int unsigned hold_left = 0;

   p95_scoreboard sb = new();

   sliding_window_p95_tracker_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_latency_sample (req_latency_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_p95_latency    (rsp_p95_latency),
      .rsp_window_fill    (rsp_window_fill),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_window_size    (csr_window_size)
   );

   // 10 ns clock
   always #5 clock = ~clock;

   // receiver side: random stall, or a long hold-off counted here cycle by cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // monitor: every handshake is seen with the values that were present before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_window_size(csr_window_size);
         if (req_valid && !req_stall) sb.note_latency(req_latency_sample);
         if (rsp_valid && !rsp_stall) sb.check_p95(rsp_p95_latency, rsp_window_fill);
      end
   end

   // offer one latency transaction, with random sender gaps ahead of it
   task automatic offer_latency(logic [IN_BITS-1:0] lat);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_latency_sample <= lat;
      do @(posedge clock); while (req_stall);
   endtask

   // sender pause until every predicted result has come back, then let the block settle
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // csr write transaction, only issued while the block is idle
   task automatic write_size(logic [CNT_BITS-1:0] value);
      csr_valid       <= 1'b1;
      csr_window_size <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // mix of full-range, negative, small, near-max and repeated latencies
   function automatic logic [IN_BITS-1:0] pick_latency(logic [IN_BITS-1:0] prev);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 40) return $urandom();
      if (r < 55) return {1'b1, 31'($urandom())};
      if (r < 75) return IN_BITS'($urandom_range(1000));
      if (r < 88) return 32'h7FFF_FFFF - IN_BITS'($urandom_range(50));
      return prev;
   endfunction

   // window sizes: mostly small, with zero, full and oversized writes mixed in
   function automatic logic [CNT_BITS-1:0] pick_size();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10) return '0;
      if (r < 25) return CNT_BITS'(WINDOW_MAX);
      if (r < 35) return CNT_BITS'($urandom_range(WINDOW_MAX + 1, 127));
      if (r < 45) return CNT_BITS'(1);
      return CNT_BITS'($urandom_range(2, 24));
   endfunction

   // main stimulus
   initial begin
      logic [IN_BITS-1:0] extremes[9];
      logic [IN_BITS-1:0] prev;
      int unsigned        n_items;
      int unsigned        ph;
      int unsigned        ch;
      int unsigned        i;
      extremes = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                   32'h0000_0001, 32'h4000_0000, 32'h7FFF_FFFE, 32'h5555_5555,
                   32'h2AAA_AAAA};
      prev = '0;

      // synchronous reset at the start
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes and negatives at the reset size of 64
      foreach (extremes[k]) offer_latency(extremes[k]);

      // small window that wraps, with duplicates
      drain_results();
      write_size(CNT_BITS'(3));
      offer_latency(10);
      offer_latency(30);
      offer_latency(20);
      offer_latency(5);
      offer_latency(5);
      offer_latency(40);

      // same size written again keeps the window
      drain_results();
      write_size(CNT_BITS'(3));
      offer_latency(7);
      offer_latency(32'h7FFF_FFFF);

      // size zero discards everything
      drain_results();
      write_size('0);
      offer_latency(32'h0000_1234);
      offer_latency(32'h8765_4321);

      // oversized write saturates to the maximum and clears
      drain_results();
      write_size(CNT_BITS'(127));
      offer_latency(100);
      offer_latency(200);

      // writing the maximum now is no change
      drain_results();
      write_size(CNT_BITS'(WINDOW_MAX));
      offer_latency(300);

      // random phases: no idling, sender idle 85, receiver stall 85, both 28
      for (ph = 0; ph < 4; ph++) begin
         idle_pct  = (ph == 1) ? 85 : (ph == 3) ? 28 : 0;
         stall_pct = (ph == 2) ? 85 : (ph == 3) ? 28 : 0;
         for (ch = 0; ch < 3; ch++) begin
            drain_results();
            if (ph == 0 && ch == 0) begin
               // full window long enough to wrap well past 64
               write_size(CNT_BITS'(WINDOW_MAX));
               n_items = 90;
            end else begin
               write_size(pick_size());
               n_items = $urandom_range(15, 35);
            end
            for (i = 0; i < n_items; i++) begin
               // long receiver hold-off while the sender keeps offering
               if (ph == 0 && ch == 0 && i == 70) hold_left = 600;
               prev = pick_latency(prev);
               offer_latency(prev);
            end
         end
      end

      drain_results();
      if (sb.expected_q.size() != 0)
         sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));

      $display("covered %0d latency transactions, %0d results, %0d window size writes",
               sb.latencies_seen, sb.results_seen, sb.size_writes);
      $display("sizes 0 to 127 incl. saturation, idle and stall mixes, one long rsp hold-off");
      if (sb.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/swpt_pkg.sv
rtl/swpt_ring.sv
rtl/swpt_sorted.sv
rtl/sliding_window_p95_tracker_top.sv
verif/sliding_window_p95_tracker_top_tb.sv
